// ----- hdl/tcp_connection_state_machine_top_defines.svh -----
// ---------------------------------------------------------------------------
// TCP connection state machine assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef TCP_CONNECTION_STATE_MACHINE_TOP_DEFINES_SVH
`define TCP_CONNECTION_STATE_MACHINE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCPSM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCPSM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/tcpsm_pkg.sv -----
// ---------------------------------------------------------------------------
// TCP connection state machine package
// Shared types, state codes, flag values and configuration register indexes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcpsm_pkg;

  typedef enum logic [10:0] {
    S_CLOSED      = 11'b000_0000_0001,
    S_LISTEN      = 11'b000_0000_0010,
    S_SYN_SENT    = 11'b000_0000_0100,
    S_SYN_RECV    = 11'b000_0000_1000,
    S_ESTABLISHED = 11'b000_0001_0000,
    S_FIN_WAIT_1  = 11'b000_0010_0000,
    S_FIN_WAIT_2  = 11'b000_0100_0000,
    S_CLOSING     = 11'b000_1000_0000,
    S_TIME_WAIT   = 11'b001_0000_0000,
    S_CLOSE_WAIT  = 11'b010_0000_0000,
    S_LAST_ACK    = 11'b100_0000_0000
  } state_t;

  localparam logic [3:0] CODE_CLOSED      = 4'd0;
  localparam logic [3:0] CODE_LISTEN      = 4'd1;
  localparam logic [3:0] CODE_SYN_SENT    = 4'd2;
  localparam logic [3:0] CODE_SYN_RECV    = 4'd3;
  localparam logic [3:0] CODE_ESTABLISHED = 4'd4;
  localparam logic [3:0] CODE_FIN_WAIT_1  = 4'd5;
  localparam logic [3:0] CODE_FIN_WAIT_2  = 4'd6;
  localparam logic [3:0] CODE_CLOSING     = 4'd7;
  localparam logic [3:0] CODE_TIME_WAIT   = 4'd8;
  localparam logic [3:0] CODE_CLOSE_WAIT  = 4'd9;
  localparam logic [3:0] CODE_LAST_ACK    = 4'd10;

  localparam logic [2:0] OP_SEGMENT = 3'd0;
  localparam logic [2:0] OP_LISTEN  = 3'd1;
  localparam logic [2:0] OP_CONNECT = 3'd2;
  localparam logic [2:0] OP_CLOSE   = 3'd3;
  localparam logic [2:0] OP_TICK    = 3'd4;

  localparam logic [3:0] FL_SYN = 4'd8;
  localparam logic [3:0] FL_ACK = 4'd4;
  localparam logic [3:0] FL_FIN = 4'd2;

  localparam logic [15:0] HEADER_LEN = 16'd20;

  localparam logic [2:0] CFG_LOCAL_PORT        = 3'd0;
  localparam logic [2:0] CFG_REMOTE_PORT       = 3'd1;
  localparam logic [2:0] CFG_SYN_ISN           = 3'd2;
  localparam logic [2:0] CFG_SYNACK_ISN        = 3'd3;
  localparam logic [2:0] CFG_HANDSHAKE_TIMEOUT = 3'd4;
  localparam logic [2:0] CFG_CLOSE_TIMEOUT     = 3'd5;

  localparam logic [15:0] HANDSHAKE_TIMEOUT_RESET = 16'd1000;
  localparam logic [15:0] CLOSE_TIMEOUT_RESET     = 16'd2000;

  typedef struct packed {
    logic [2:0]  operation;
    logic [7:0]  seg_flags;
    logic [31:0] seg_seq;
    logic [31:0] seg_ack;
    logic [15:0] seg_src_port;
    logic [15:0] seg_length;
  } evt_t;

  typedef struct packed {
    logic [15:0] local_port;
    logic [15:0] remote_port;
    logic [31:0] syn_isn;
    logic [31:0] synack_isn;
    logic [15:0] handshake_timeout;
    logic [15:0] close_timeout;
  } cfg_t;

  typedef struct packed {
    logic        send_valid;
    logic [3:0]  send_flags;
    logic [31:0] send_seq;
    logic [31:0] send_ack;
    logic [15:0] send_src_port;
    logic [15:0] send_dst_port;
    logic [3:0]  conn_state;
    logic        status;
  } result_t;

  function automatic logic [3:0] encode_state(input state_t s);
    logic [3:0] code;
    case (s)
      S_CLOSED:      code = CODE_CLOSED;
      S_LISTEN:      code = CODE_LISTEN;
      S_SYN_SENT:    code = CODE_SYN_SENT;
      S_SYN_RECV:    code = CODE_SYN_RECV;
      S_ESTABLISHED: code = CODE_ESTABLISHED;
      S_FIN_WAIT_1:  code = CODE_FIN_WAIT_1;
      S_FIN_WAIT_2:  code = CODE_FIN_WAIT_2;
      S_CLOSING:     code = CODE_CLOSING;
      S_TIME_WAIT:   code = CODE_TIME_WAIT;
      S_CLOSE_WAIT:  code = CODE_CLOSE_WAIT;
      S_LAST_ACK:    code = CODE_LAST_ACK;
      default:       code = CODE_CLOSED;
    endcase
    return code;
  endfunction

  function automatic logic in_fin_group(input state_t s);
    return (s == S_FIN_WAIT_1) || (s == S_FIN_WAIT_2) || (s == S_CLOSING);
  endfunction

endpackage

`default_nettype wire

// ----- hdl/tcp_connection_state_machine_top.sv -----
// ---------------------------------------------------------------------------
// TCP connection state machine top level
// Taken events are registered, then their results. Throughput: one event per cycle
// unless the result channel stalls; the state update is a single pass of
// compare and select logic between the event register and the result register.
// Reset clears the connection to CLOSED, all saved numbers and the timer to
// zero, and the timeouts to 1000 and 2000 ticks; the block takes events at once.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "tcp_connection_state_machine_top_defines.svh"

module tcp_connection_state_machine_top
  import tcpsm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write_enable,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        event_valid,
  output logic             event_stall,
  input  wire logic [2:0]  operation,
  input  wire logic [7:0]  seg_flags,
  input  wire logic [31:0] seg_seq,
  input  wire logic [31:0] seg_ack,
  input  wire logic [15:0] seg_src_port,
  input  wire logic [15:0] seg_length,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic             send_valid,
  output logic [3:0]       send_flags,
  output logic [31:0]      send_seq,
  output logic [31:0]      send_ack,
  output logic [15:0]      send_src_port,
  output logic [15:0]      send_dst_port,
  output logic [3:0]       conn_state,
  output logic             status
);

  cfg_t    cfg;
  evt_t    evt;
  logic    evt_valid;
  result_t res_comb, res;
  logic    out_free, step, accept;

  assign out_free    = !result_valid || !result_stall;
  assign step        = evt_valid && out_free;
  assign event_stall = evt_valid && !out_free;
  assign accept      = event_valid && !event_stall;

  tcpsm_cfg u_cfg (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cfg              (cfg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      evt_valid <= 1'b0;
    end else if (accept) begin
      evt_valid <= 1'b1;
    end else if (step) begin
      evt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      evt.operation    <= operation;
      evt.seg_flags    <= seg_flags;
      evt.seg_seq      <= seg_seq;
      evt.seg_ack      <= seg_ack;
      evt.seg_src_port <= seg_src_port;
      evt.seg_length   <= seg_length;
    end
  end

  tcpsm_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .evt  (evt),
    .cfg  (cfg),
    .res  (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res <= res_comb;
    end
  end

  assign send_valid    = res.send_valid;
  assign send_flags    = res.send_flags;
  assign send_seq      = res.send_seq;
  assign send_ack      = res.send_ack;
  assign send_src_port = res.send_src_port;
  assign send_dst_port = res.send_dst_port;
  assign conn_state    = res.conn_state;
  assign status        = res.status;

  `TCPSM_ASSERT_NEXT(a_step_gives_result, clk, rst, step, result_valid, "processed event lost its result")
  `TCPSM_ASSERT_SAME(a_refused_sends_nothing, clk, rst, result_valid && res.status, !res.send_valid, "refused close sent a segment")
  `TCPSM_ASSERT_SAME(a_no_segment_zero, clk, rst, result_valid && !res.send_valid, res.send_flags == 4'd0 && res.send_seq == 32'd0 && res.send_src_port == 16'd0, "empty segment fields not zero")

endmodule

`default_nettype wire

// ----- hdl/tcpsm_cfg.sv -----
// ---------------------------------------------------------------------------
// TCP connection state machine configuration registers
// Holds ports, initial sequence numbers and timeouts written by the host.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcpsm_cfg
  import tcpsm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write_enable,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.local_port        <= '0;
      cfg.remote_port       <= '0;
      cfg.syn_isn           <= '0;
      cfg.synack_isn        <= '0;
      cfg.handshake_timeout <= HANDSHAKE_TIMEOUT_RESET;
      cfg.close_timeout     <= CLOSE_TIMEOUT_RESET;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        CFG_LOCAL_PORT:        cfg.local_port        <= cfg_data[15:0];
        CFG_REMOTE_PORT:       cfg.remote_port       <= cfg_data[15:0];
        CFG_SYN_ISN:           cfg.syn_isn           <= cfg_data;
        CFG_SYNACK_ISN:        cfg.synack_isn        <= cfg_data;
        CFG_HANDSHAKE_TIMEOUT: cfg.handshake_timeout <= cfg_data[15:0];
        CFG_CLOSE_TIMEOUT:     cfg.close_timeout     <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/tcpsm_core.sv -----
// ---------------------------------------------------------------------------
// TCP connection state machine core
// Connection state, timer and saved segment numbers, with the per-event
// next-state and segment logic.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcpsm_core
  import tcpsm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic step,
  input  wire evt_t evt,
  input  wire cfg_t cfg,
  output result_t   res
);

  state_t      state, state_next, go_state;
  logic [15:0] tick_count, tick_count_next, tick_timed;
  logic [15:0] peer_port, peer_port_next;
  logic [31:0] synack_ack_number, synack_ack_number_next;
  logic [31:0] hs_ack_seq, hs_ack_seq_next;
  logic [31:0] hs_ack_ack, hs_ack_ack_next;
  logic [31:0] fin_ack_seq, fin_ack_seq_next;
  logic [31:0] fin_ack_ack, fin_ack_ack_next;

  logic        go_en, force_tick_clear, fire, rx_fin;
  logic [15:0] limit;
  logic        emit;
  logic [3:0]  emit_flags;
  logic [31:0] emit_seq, emit_ack, seq_plus_one;
  logic        refused;

  assign rx_fin       = (evt.seg_flags == {4'd0, FL_FIN}) ||
                        (evt.seg_flags == {4'd0, FL_FIN | FL_ACK});
  assign seq_plus_one = evt.seg_seq + 32'd1;
  assign limit        = (in_fin_group(state) || state == S_TIME_WAIT) ?
                        cfg.close_timeout : cfg.handshake_timeout;
  assign fire         = tick_count >= limit;

  always_comb begin
    go_en                  = 1'b0;
    go_state               = state;
    force_tick_clear       = 1'b0;
    tick_timed             = tick_count;
    peer_port_next         = peer_port;
    synack_ack_number_next = synack_ack_number;
    hs_ack_seq_next        = hs_ack_seq;
    hs_ack_ack_next        = hs_ack_ack;
    fin_ack_seq_next       = fin_ack_seq;
    fin_ack_ack_next       = fin_ack_ack;
    emit                   = 1'b0;
    emit_flags             = '0;
    emit_seq               = '0;
    emit_ack               = '0;
    refused                = 1'b0;

    case (evt.operation)
      OP_SEGMENT: begin
        case (state)
          S_LISTEN: begin
            if (evt.seg_flags == {4'd0, FL_SYN}) begin
              peer_port_next         = evt.seg_src_port;
              synack_ack_number_next = seq_plus_one;
              emit       = 1'b1;
              emit_flags = FL_SYN | FL_ACK;
              emit_seq   = cfg.synack_isn;
              emit_ack   = seq_plus_one;
              go_en      = 1'b1;
              go_state   = S_SYN_RECV;
            end
          end
          S_SYN_SENT: begin
            if (evt.seg_flags == {4'd0, FL_SYN | FL_ACK}) begin
              hs_ack_seq_next = evt.seg_ack;
              hs_ack_ack_next = seq_plus_one;
              emit       = 1'b1;
              emit_flags = FL_ACK;
              emit_seq   = evt.seg_ack;
              emit_ack   = seq_plus_one;
              go_en      = 1'b1;
              go_state   = S_ESTABLISHED;
            end
          end
          S_SYN_RECV: begin
            if (evt.seg_flags == {4'd0, FL_ACK} && evt.seg_length == HEADER_LEN) begin
              go_en    = 1'b1;
              go_state = S_ESTABLISHED;
            end else if (evt.seg_flags == {4'd0, FL_SYN}) begin
              emit       = 1'b1;
              emit_flags = FL_SYN | FL_ACK;
              emit_seq   = cfg.synack_isn;
              emit_ack   = synack_ack_number;
            end
          end
          S_ESTABLISHED: begin
            if (evt.seg_flags == {4'd0, FL_SYN | FL_ACK}) begin
              emit       = 1'b1;
              emit_flags = FL_ACK;
              emit_seq   = hs_ack_seq;
              emit_ack   = hs_ack_ack;
            end else if (rx_fin) begin
              fin_ack_seq_next = evt.seg_ack;
              fin_ack_ack_next = seq_plus_one;
              emit       = 1'b1;
              emit_flags = FL_ACK;
              emit_seq   = evt.seg_ack;
              emit_ack   = seq_plus_one;
              go_en      = 1'b1;
              go_state   = S_CLOSE_WAIT;
            end
          end
          S_FIN_WAIT_1: begin
            if (rx_fin) begin
              fin_ack_seq_next = evt.seg_ack;
              fin_ack_ack_next = seq_plus_one;
              emit       = 1'b1;
              emit_flags = FL_ACK;
              emit_seq   = evt.seg_ack;
              emit_ack   = seq_plus_one;
              go_en      = 1'b1;
              go_state   = S_CLOSING;
            end else if (evt.seg_flags == {4'd0, FL_ACK}) begin
              go_en    = 1'b1;
              go_state = S_FIN_WAIT_2;
            end
          end
          S_CLOSING: begin
            if (evt.seg_flags == {4'd0, FL_ACK}) begin
              emit       = 1'b1;
              emit_flags = FL_ACK;
              emit_seq   = fin_ack_seq;
              emit_ack   = fin_ack_ack;
              go_en      = 1'b1;
              go_state   = S_TIME_WAIT;
            end else if (rx_fin) begin
              emit       = 1'b1;
              emit_flags = FL_ACK;
              emit_seq   = fin_ack_seq;
              emit_ack   = fin_ack_ack;
            end
          end
          S_FIN_WAIT_2: begin
            if (rx_fin) begin
              fin_ack_seq_next = evt.seg_ack;
              fin_ack_ack_next = seq_plus_one;
              emit       = 1'b1;
              emit_flags = FL_ACK;
              emit_seq   = evt.seg_ack;
              emit_ack   = seq_plus_one;
              go_en      = 1'b1;
              go_state   = S_TIME_WAIT;
            end
          end
          S_CLOSE_WAIT: begin
            if (evt.seg_flags == {4'd0, FL_FIN}) begin
              emit       = 1'b1;
              emit_flags = FL_ACK;
              emit_seq   = fin_ack_seq;
              emit_ack   = fin_ack_ack;
            end
          end
          S_LAST_ACK: begin
            if (evt.seg_flags == {4'd0, FL_ACK}) begin
              go_en    = 1'b1;
              go_state = S_CLOSED;
            end
          end
          default: begin
          end
        endcase
      end
      OP_LISTEN: begin
        go_en    = 1'b1;
        go_state = S_LISTEN;
      end
      OP_CONNECT: begin
        peer_port_next   = cfg.remote_port;
        emit             = 1'b1;
        emit_flags       = FL_SYN;
        emit_seq         = cfg.syn_isn;
        go_en            = 1'b1;
        go_state         = S_SYN_SENT;
        force_tick_clear = 1'b1;
      end
      OP_CLOSE: begin
        if (state == S_ESTABLISHED || state == S_CLOSE_WAIT) begin
          emit       = 1'b1;
          emit_flags = FL_FIN | FL_ACK;
          go_en      = 1'b1;
          go_state   = (state == S_ESTABLISHED) ? S_FIN_WAIT_1 : S_LAST_ACK;
        end else begin
          refused = 1'b1;
        end
      end
      OP_TICK: begin
        case (state)
          S_SYN_SENT, S_SYN_RECV, S_FIN_WAIT_1, S_FIN_WAIT_2, S_CLOSING,
          S_TIME_WAIT, S_LAST_ACK: begin
            tick_timed = fire ? 16'd0 : tick_count + 16'd1;
            if (fire) begin
              case (state)
                S_SYN_SENT: begin
                  emit       = 1'b1;
                  emit_flags = FL_SYN;
                  emit_seq   = cfg.syn_isn;
                end
                S_SYN_RECV: begin
                  emit       = 1'b1;
                  emit_flags = FL_SYN | FL_ACK;
                  emit_seq   = cfg.synack_isn;
                  emit_ack   = synack_ack_number;
                end
                S_TIME_WAIT: begin
                  go_en    = 1'b1;
                  go_state = S_CLOSED;
                end
                S_LAST_ACK: begin
                  emit       = 1'b1;
                  emit_flags = FL_FIN | FL_ACK;
                  go_en      = 1'b1;
                  go_state   = S_CLOSED;
                end
                default: begin
                  emit       = 1'b1;
                  emit_flags = FL_FIN | FL_ACK;
                end
              endcase
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    state_next      = go_en ? go_state : state;
    tick_count_next = tick_timed;
    if (force_tick_clear ||
        (go_en && go_state != state && !(in_fin_group(go_state) && in_fin_group(state)))) begin
      tick_count_next = '0;
    end
  end

  always_comb begin
    res.send_valid    = emit;
    res.send_flags    = emit_flags;
    res.send_seq      = emit_seq;
    res.send_ack      = emit_ack;
    res.send_src_port = emit ? cfg.local_port : 16'd0;
    res.send_dst_port = emit ? peer_port_next : 16'd0;
    res.conn_state    = encode_state(state_next);
    res.status        = refused;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_CLOSED;
      tick_count        <= '0;
      peer_port         <= '0;
      synack_ack_number <= '0;
      hs_ack_seq        <= '0;
      hs_ack_ack        <= '0;
      fin_ack_seq       <= '0;
      fin_ack_ack       <= '0;
    end else if (step) begin
      state             <= state_next;
      tick_count        <= tick_count_next;
      peer_port         <= peer_port_next;
      synack_ack_number <= synack_ack_number_next;
      hs_ack_seq        <= hs_ack_seq_next;
      hs_ack_ack        <= hs_ack_ack_next;
      fin_ack_seq       <= fin_ack_seq_next;
      fin_ack_ack       <= fin_ack_ack_next;
    end
  end

endmodule

`default_nettype wire

// ----- tb/tcp_connection_state_machine_top_tb.sv -----
// ---------------------------------------------------------------------------
// TCP connection state machine testbench
// Drives connection events through the event channel with random gaps and
// result stalls. Each accepted event is run through a behavioral model of the
// connection, and every result is compared field by field with the model.
// Settings change between phases, once every predicted result has arrived.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcp_connection_state_machine_top_tb;
  import tcpsm_pkg::*;

  localparam int IDLE_LIMIT = 500;
  localparam int QUIET_CYCLES = 8;
  localparam int PHASE_COUNT = 8;
  localparam int PHASE_EVENTS = 125;
  localparam logic [2:0] OP_UNDEFINED_FIRST = 3'd5;
  localparam logic [2:0] OP_UNDEFINED_LAST = 3'd7;
  localparam logic [7:0] RX_SYN = {4'd0, FL_SYN};
  localparam logic [7:0] RX_ACK = {4'd0, FL_ACK};
  localparam logic [7:0] RX_FIN = {4'd0, FL_FIN};
  localparam logic [7:0] RX_SYNACK = {4'd0, FL_SYN | FL_ACK};
  localparam logic [7:0] RX_FINACK = {4'd0, FL_FIN | FL_ACK};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_enable = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        event_valid = 1'b0;
  logic [2:0]  operation = '0;
  logic [7:0]  seg_flags = '0;
  logic [31:0] seg_seq = '0;
  logic [31:0] seg_ack = '0;
  logic [15:0] seg_src_port = '0;
  logic [15:0] seg_length = '0;
  logic        result_stall = 1'b0;
  logic        event_stall;
  logic        result_valid;
  logic        send_valid;
  logic [3:0]  send_flags;
  logic [31:0] send_seq;
  logic [31:0] send_ack;
  logic [15:0] send_src_port;
  logic [15:0] send_dst_port;
  logic [3:0]  conn_state;
  logic        status;

  tcp_connection_state_machine_top dut (
    .clk(clk),
    .rst(rst),
    .cfg_write_enable(cfg_write_enable),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .event_valid(event_valid),
    .event_stall(event_stall),
    .operation(operation),
    .seg_flags(seg_flags),
    .seg_seq(seg_seq),
    .seg_ack(seg_ack),
    .seg_src_port(seg_src_port),
    .seg_length(seg_length),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .send_valid(send_valid),
    .send_flags(send_flags),
    .send_seq(send_seq),
    .send_ack(send_ack),
    .send_src_port(send_src_port),
    .send_dst_port(send_dst_port),
    .conn_state(conn_state),
    .status(status)
  );

  cfg_t        m_cfg = '{16'd0, 16'd0, 32'd0, 32'd0, HANDSHAKE_TIMEOUT_RESET,
                         CLOSE_TIMEOUT_RESET};
  logic [3:0]  m_state = CODE_CLOSED;
  logic [15:0] m_ticks = '0;
  logic [15:0] m_peer = '0;
  logic [31:0] m_synack_ack = '0;
  logic [31:0] m_hs_seq = '0;
  logic [31:0] m_hs_ack = '0;
  logic [31:0] m_fin_seq = '0;
  logic [31:0] m_fin_ack = '0;

  evt_t    queued_events[$];
  result_t pending_replies[$];
  int      events_queued = 0;
  int      mismatch_count = 0;
  int      idle_cycles = 0;
  int      gap_left = 0;
  int      stall_left = 0;
  bit      event_taken = 1'b0;
  bit      result_taken = 1'b0;
  bit      no_gaps = 1'b0;
  logic [15:0] phase_hs = HANDSHAKE_TIMEOUT_RESET;
  logic [15:0] phase_close = CLOSE_TIMEOUT_RESET;
  evt_t    ev_now;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic bit shares_fin_timer(input logic [3:0] s);
    return (s == CODE_FIN_WAIT_1) || (s == CODE_FIN_WAIT_2) || (s == CODE_CLOSING);
  endfunction

  function automatic void move_to(input logic [3:0] next);
    if (next != m_state && !(shares_fin_timer(next) && shares_fin_timer(m_state))) begin
      m_ticks = '0;
    end
    m_state = next;
  endfunction

  function automatic bit timer_fires(input logic [15:0] limit);
    if (m_ticks >= limit) begin
      m_ticks = '0;
      return 1'b1;
    end
    m_ticks = m_ticks + 16'd1;
    return 1'b0;
  endfunction

  function automatic result_t segment_out(input logic [3:0] flags, input logic [31:0] seq,
                                          input logic [31:0] ack);
    result_t r;
    r = '0;
    r.send_valid = 1'b1;
    r.send_flags = flags;
    r.send_seq = seq;
    r.send_ack = ack;
    r.send_src_port = m_cfg.local_port;
    r.send_dst_port = m_peer;
    return r;
  endfunction

  function automatic result_t advance_connection(input evt_t ev);
    result_t    r;
    logic [7:0] fl;
    logic       fin;
    logic       refused;
    r = '0;
    refused = 1'b0;
    fl = ev.seg_flags;
    fin = (fl == RX_FIN) || (fl == RX_FINACK);
    case (ev.operation)
      OP_SEGMENT: begin
        case (m_state)
          CODE_LISTEN: begin
            if (fl == RX_SYN) begin
              m_peer = ev.seg_src_port;
              m_synack_ack = ev.seg_seq + 32'd1;
              r = segment_out(FL_SYN | FL_ACK, m_cfg.synack_isn, m_synack_ack);
              move_to(CODE_SYN_RECV);
            end
          end
          CODE_SYN_SENT: begin
            if (fl == RX_SYNACK) begin
              m_hs_seq = ev.seg_ack;
              m_hs_ack = ev.seg_seq + 32'd1;
              r = segment_out(FL_ACK, m_hs_seq, m_hs_ack);
              move_to(CODE_ESTABLISHED);
            end
          end
          CODE_SYN_RECV: begin
            if (fl == RX_ACK && ev.seg_length == HEADER_LEN) begin
              move_to(CODE_ESTABLISHED);
            end else if (fl == RX_SYN) begin
              r = segment_out(FL_SYN | FL_ACK, m_cfg.synack_isn, m_synack_ack);
            end
          end
          CODE_ESTABLISHED: begin
            if (fl == RX_SYNACK) begin
              r = segment_out(FL_ACK, m_hs_seq, m_hs_ack);
            end else if (fin) begin
              m_fin_seq = ev.seg_ack;
              m_fin_ack = ev.seg_seq + 32'd1;
              r = segment_out(FL_ACK, m_fin_seq, m_fin_ack);
              move_to(CODE_CLOSE_WAIT);
            end
          end
          CODE_FIN_WAIT_1: begin
            if (fin) begin
              m_fin_seq = ev.seg_ack;
              m_fin_ack = ev.seg_seq + 32'd1;
              r = segment_out(FL_ACK, m_fin_seq, m_fin_ack);
              move_to(CODE_CLOSING);
            end else if (fl == RX_ACK) begin
              move_to(CODE_FIN_WAIT_2);
            end
          end
          CODE_CLOSING: begin
            if (fl == RX_ACK) begin
              r = segment_out(FL_ACK, m_fin_seq, m_fin_ack);
              move_to(CODE_TIME_WAIT);
            end else if (fin) begin
              r = segment_out(FL_ACK, m_fin_seq, m_fin_ack);
            end
          end
          CODE_FIN_WAIT_2: begin
            if (fin) begin
              m_fin_seq = ev.seg_ack;
              m_fin_ack = ev.seg_seq + 32'd1;
              r = segment_out(FL_ACK, m_fin_seq, m_fin_ack);
              move_to(CODE_TIME_WAIT);
            end
          end
          CODE_CLOSE_WAIT: begin
            if (fl == RX_FIN) begin
              r = segment_out(FL_ACK, m_fin_seq, m_fin_ack);
            end
          end
          CODE_LAST_ACK: begin
            if (fl == RX_ACK) begin
              move_to(CODE_CLOSED);
            end
          end
          default: begin
          end
        endcase
      end
      OP_LISTEN: begin
        move_to(CODE_LISTEN);
      end
      OP_CONNECT: begin
        m_peer = m_cfg.remote_port;
        r = segment_out(FL_SYN, m_cfg.syn_isn, 32'd0);
        move_to(CODE_SYN_SENT);
        m_ticks = '0;
      end
      OP_CLOSE: begin
        if (m_state == CODE_ESTABLISHED) begin
          r = segment_out(FL_FIN | FL_ACK, 32'd0, 32'd0);
          move_to(CODE_FIN_WAIT_1);
        end else if (m_state == CODE_CLOSE_WAIT) begin
          r = segment_out(FL_FIN | FL_ACK, 32'd0, 32'd0);
          move_to(CODE_LAST_ACK);
        end else begin
          refused = 1'b1;
        end
      end
      OP_TICK: begin
        case (m_state)
          CODE_SYN_SENT: begin
            if (timer_fires(m_cfg.handshake_timeout)) begin
              r = segment_out(FL_SYN, m_cfg.syn_isn, 32'd0);
            end
          end
          CODE_SYN_RECV: begin
            if (timer_fires(m_cfg.handshake_timeout)) begin
              r = segment_out(FL_SYN | FL_ACK, m_cfg.synack_isn, m_synack_ack);
            end
          end
          CODE_FIN_WAIT_1, CODE_FIN_WAIT_2, CODE_CLOSING: begin
            if (timer_fires(m_cfg.close_timeout)) begin
              r = segment_out(FL_FIN | FL_ACK, 32'd0, 32'd0);
            end
          end
          CODE_TIME_WAIT: begin
            if (timer_fires(m_cfg.close_timeout)) begin
              move_to(CODE_CLOSED);
            end
          end
          CODE_LAST_ACK: begin
            if (timer_fires(m_cfg.handshake_timeout)) begin
              r = segment_out(FL_FIN | FL_ACK, 32'd0, 32'd0);
              move_to(CODE_CLOSED);
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
    r.conn_state = m_state;
    r.status = refused;
    return r;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  // Event driver: presents queued transactions, with a drawn gap after each one.
  always @(negedge clk) begin
    if (!rst) begin
      if (event_valid && event_taken) begin
        event_valid = 1'b0;
        gap_left = no_gaps ? 0 : $urandom_range(0, 11);
      end
      if (!event_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (queued_events.size() > 0) begin
          ev_now = queued_events.pop_front();
          operation = ev_now.operation;
          seg_flags = ev_now.seg_flags;
          seg_seq = ev_now.seg_seq;
          seg_ack = ev_now.seg_ack;
          seg_src_port = ev_now.seg_src_port;
          seg_length = ev_now.seg_length;
          event_valid = 1'b1;
        end
      end
    end
  end

  // Result stall: a drawn number of stalled cycles after each result transaction.
  always @(negedge clk) begin
    if (result_taken) begin
      stall_left = no_gaps ? 0 : $urandom_range(0, 11);
    end
    if (stall_left > 0) begin
      result_stall = 1'b1;
      stall_left--;
    end else begin
      result_stall = 1'b0;
    end
  end

  always @(posedge clk) begin : monitor
    evt_t    taken_ev;
    result_t seen;
    result_t want;
    if (rst) begin
      event_taken = 1'b0;
      result_taken = 1'b0;
      idle_cycles = 0;
    end else begin
      event_taken = event_valid && !event_stall;
      result_taken = result_valid && !result_stall;
      if (event_taken) begin
        taken_ev = {operation, seg_flags, seg_seq, seg_ack, seg_src_port, seg_length};
        pending_replies.push_back(advance_connection(taken_ev));
      end
      if (result_taken) begin
        seen = {send_valid, send_flags, send_seq, send_ack, send_src_port, send_dst_port,
                conn_state, status};
        if (pending_replies.size() == 0) begin
          $display("%0t: result with none expected, expected nothing, actual %h", $time, seen);
          mismatch_count++;
        end else begin
          want = pending_replies.pop_front();
          check_field("send_valid", 32'(want.send_valid), 32'(seen.send_valid));
          check_field("send_flags", 32'(want.send_flags), 32'(seen.send_flags));
          check_field("send_seq", want.send_seq, seen.send_seq);
          check_field("send_ack", want.send_ack, seen.send_ack);
          check_field("send_src_port", 32'(want.send_src_port), 32'(seen.send_src_port));
          check_field("send_dst_port", 32'(want.send_dst_port), 32'(seen.send_dst_port));
          check_field("conn_state", 32'(want.conn_state), 32'(seen.conn_state));
          check_field("status", 32'(want.status), 32'(seen.status));
        end
      end
      if (event_taken || result_taken || cfg_write_enable) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  task automatic push_event(input logic [2:0] op, input logic [7:0] flags,
                            input logic [31:0] seq, input logic [31:0] ack,
                            input logic [15:0] src, input logic [15:0] len);
    evt_t ev;
    ev.operation = op;
    ev.seg_flags = flags;
    ev.seg_seq = seq;
    ev.seg_ack = ack;
    ev.seg_src_port = src;
    ev.seg_length = len;
    queued_events.push_back(ev);
    events_queued++;
  endtask

  task automatic add_request(input logic [2:0] op);
    push_event(op, 8'($urandom), $urandom, $urandom, 16'($urandom), 16'($urandom));
  endtask

  task automatic add_segment(input logic [7:0] flags);
    logic [15:0] len;
    len = ($urandom_range(0, 7) == 0) ? 16'($urandom) : HEADER_LEN;
    push_event(OP_SEGMENT, flags, $urandom, $urandom, 16'($urandom), len);
  endtask

  task automatic add_ticks(input logic [15:0] limit);
    int n;
    n = (limit < 16'd8) ? $urandom_range(0, limit + 2) : $urandom_range(0, 3);
    repeat (n) add_request(OP_TICK);
  endtask

  task automatic add_noise();
    logic [7:0] flags;
    case ($urandom_range(0, 5))
      0: flags = RX_SYN;
      1: flags = RX_ACK;
      2: flags = RX_FIN;
      3: flags = RX_FINACK;
      4: flags = RX_SYNACK;
      default: flags = 8'($urandom);
    endcase
    push_event(3'($urandom_range(OP_SEGMENT, OP_UNDEFINED_LAST)), flags, $urandom, $urandom,
               16'($urandom), ($urandom_range(0, 1) == 0) ? HEADER_LEN : 16'($urandom));
  endtask

  task automatic add_fin();
    add_segment(($urandom_range(0, 1) == 0) ? RX_FIN : RX_FINACK);
  endtask

  task automatic add_teardown();
    case ($urandom_range(0, 3))
      0: begin
        add_request(OP_CLOSE);
        add_ticks(phase_close);
        add_segment(RX_ACK);
        add_ticks(phase_close);
        add_fin();
        add_ticks(phase_close);
      end
      1: begin
        add_request(OP_CLOSE);
        add_fin();
        add_ticks(phase_close);
        add_segment(RX_ACK);
        add_ticks(phase_close);
      end
      2: begin
        add_fin();
        if ($urandom_range(0, 1) == 0) add_segment(RX_FIN);
        if ($urandom_range(0, 2) == 0) add_segment(RX_ACK);
        add_request(OP_CLOSE);
        if ($urandom_range(0, 1) == 0) add_segment(RX_ACK);
        else add_ticks(phase_hs);
      end
      default: begin
      end
    endcase
  endtask

  task automatic add_connection_scenario();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      add_request(OP_LISTEN);
      if ($urandom_range(0, 3) == 0) add_noise();
      add_segment(RX_SYN);
      if ($urandom_range(0, 2) == 0) add_segment(RX_SYN);
      add_ticks(phase_hs);
      add_segment(RX_ACK);
      add_teardown();
    end else if (pick < 7) begin
      add_request(OP_CONNECT);
      add_ticks(phase_hs);
      add_segment(RX_SYNACK);
      if ($urandom_range(0, 2) == 0) add_segment(RX_SYNACK);
      add_teardown();
    end else begin
      repeat ($urandom_range(1, 4)) add_noise();
    end
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_write_enable = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    case (idx)
      CFG_LOCAL_PORT:        m_cfg.local_port = value[15:0];
      CFG_REMOTE_PORT:       m_cfg.remote_port = value[15:0];
      CFG_SYN_ISN:           m_cfg.syn_isn = value;
      CFG_SYNACK_ISN:        m_cfg.synack_isn = value;
      CFG_HANDSHAKE_TIMEOUT: m_cfg.handshake_timeout = value[15:0];
      CFG_CLOSE_TIMEOUT:     m_cfg.close_timeout = value[15:0];
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_write_enable = 1'b0;
  endtask

  task automatic set_connection_config(input logic [15:0] lport, input logic [15:0] rport,
                                       input logic [31:0] c_isn, input logic [31:0] s_isn,
                                       input logic [15:0] hs, input logic [15:0] cl);
    write_register(CFG_LOCAL_PORT, {16'd0, lport});
    write_register(CFG_REMOTE_PORT, {16'd0, rport});
    write_register(CFG_SYN_ISN, c_isn);
    write_register(CFG_SYNACK_ISN, s_isn);
    write_register(CFG_HANDSHAKE_TIMEOUT, {16'd0, hs});
    write_register(CFG_CLOSE_TIMEOUT, {16'd0, cl});
    phase_hs = hs;
    phase_close = cl;
  endtask

  task automatic wait_until_quiet();
    while (queued_events.size() > 0 || event_valid || pending_replies.size() > 0) begin
      @(negedge clk);
    end
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  initial begin
    int phase_goal;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    set_connection_config(16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 32'h0, 16'd1, 16'd2);
    add_request(OP_CLOSE);
    add_request(OP_UNDEFINED_FIRST);
    add_request(OP_UNDEFINED_LAST);
    add_request(OP_LISTEN);
    push_event(OP_SEGMENT, RX_SYN, 32'hFFFF_FFFF, $urandom, 16'hFFFF, 16'hFFFF);
    add_segment(RX_SYN);
    add_request(OP_TICK);
    add_request(OP_TICK);
    push_event(OP_SEGMENT, RX_ACK, $urandom, $urandom, 16'($urandom), HEADER_LEN + 16'd1);
    push_event(OP_SEGMENT, 8'hFF, 32'h0, 32'h0, 16'h0, HEADER_LEN);
    push_event(OP_SEGMENT, RX_ACK, $urandom, $urandom, 16'($urandom), HEADER_LEN);
    add_segment(RX_SYNACK);
    push_event(OP_SEGMENT, RX_FIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0, 16'h0);
    add_segment(RX_FIN);
    add_segment(RX_ACK);
    add_request(OP_CLOSE);
    add_request(OP_TICK);
    add_request(OP_TICK);
    add_request(OP_CONNECT);
    add_segment(RX_SYNACK);
    add_request(OP_CLOSE);
    add_segment(RX_FINACK);
    add_segment(RX_ACK);
    repeat (3) add_request(OP_TICK);

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      wait_until_quiet();
      if (phase == 0) begin
        set_connection_config(16'h0000, 16'hFFFF, 32'h0, 32'hFFFF_FFFF, 16'd1, 16'd1);
      end else if (phase == 3) begin
        set_connection_config(16'($urandom), 16'($urandom), $urandom, $urandom,
                              16'hFFFF, 16'hFFFF);
      end else begin
        set_connection_config(16'($urandom), 16'($urandom), $urandom, $urandom,
                              16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)));
      end
      no_gaps = (phase % 3 == 2);
      phase_goal = events_queued + PHASE_EVENTS;
      while (events_queued < phase_goal) add_connection_scenario();
    end

    wait_until_quiet();
    if (mismatch_count == 0 && pending_replies.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/tcpsm_pkg.sv
hdl/tcpsm_cfg.sv
hdl/tcpsm_core.sv
hdl/tcp_connection_state_machine_top.sv
tb/tcp_connection_state_machine_top_tb.sv
